[rtl/esfd_pkg.sv]
// shared types, constants and codes of the escaped sensor frame decoder
package esfd_pkg;

	// default sizing
	localparam int STORE_DEPTH_DEF  = 64;
	localparam int PLAIN_PREFIX_DEF = 10;

	// only the first bytes of a frame are ever decoded
	localparam int CAP_BYTES = 42;
	localparam int MIN_FRAME = 42;

	// byte values of the frame format
	localparam logic [7:0] ESC_BYTE   = 8'hA5;
	localparam logic [7:0] HDR_BYTE   = 8'hAA;
	localparam logic [7:0] TAIL_BYTE  = 8'h55;
	localparam logic [7:0] ADDR_BYTE  = 8'h12;
	localparam logic [7:0] FUNC_BYTE  = 8'h83;
	localparam logic [7:0] START_BYTE = 8'h0C;
	localparam logic [7:0] LEN_BYTE   = 8'h1C;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_HEADER = 3'd2,
		ST_ADDR   = 3'd3,
		ST_START  = 3'd4,
		ST_LENGTH = 3'd5,
		ST_TAIL   = 3'd6
	} status_t;

	// captured head of the frame, byte i at [i]
	typedef logic [CAP_BYTES-1:0][7:0] frame_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [6:0]         frame_length;
		logic [3:0]         drop_flags;
		logic [4:0]         ir_flags;
		logic [1:0]         bump_flags;
		logic signed [15:0] angle_position;
		logic signed [31:0] left_wheel_position;
		logic signed [31:0] right_wheel_position;
		logic signed [31:0] linear_velocity;
		logic signed [31:0] turn_velocity;
		logic [7:0]         battery_level;
	} result_t;

	// bytes produced by one raw byte after escape removal
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] first;
		logic [7:0] second;
		logic       pending;
	} put_t;

endpackage

[rtl/esfd_unescape.sv]
// escape removal for one raw byte
module esfd_unescape import esfd_pkg::*; (
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	input  logic       in_prefix,
	input  logic       pending,
	output put_t       put
);

	logic is_esc;
	logic is_escaped_class;

	assign is_esc           = (data_byte == ESC_BYTE);
	assign is_escaped_class = is_esc || (data_byte == HDR_BYTE) || (data_byte == TAIL_BYTE);

	// decide which bytes go to the store
	always_comb begin
		put = '0;
		if (in_prefix) begin
			put.count = 2'd1;
			put.first = data_byte;
		end else if (pending) begin
			if (is_escaped_class) begin
				put.count = 2'd1;
				put.first = data_byte;
			end else begin
				put.count  = 2'd2;
				put.first  = ESC_BYTE;
				put.second = data_byte;
			end
		end else if (is_esc) begin
			// a lone escape at the end of the frame is kept as data
			if (frame_end) begin
				put.count = 2'd1;
				put.first = ESC_BYTE;
			end else begin
				put.pending = 1'b1;
			end
		end else begin
			put.count = 2'd1;
			put.first = data_byte;
		end
	end

endmodule

[rtl/esfd_check.sv]
// frame checks and field unpacking from the captured frame head
module esfd_check import esfd_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  frame_t                             frame,
	input  logic [$clog2(STORE_DEPTH+1)-1:0]   count,
	output result_t                            result
);

	localparam int CntW = $clog2(STORE_DEPTH + 1);

	status_t status;

	// checks in priority order
	always_comb begin
		if (count < CntW'(MIN_FRAME)) begin
			status = ST_SHORT;
		end else if (frame[0] != HDR_BYTE || frame[1] != HDR_BYTE) begin
			status = ST_HEADER;
		end else if (frame[2] != ADDR_BYTE || frame[3] != FUNC_BYTE) begin
			status = ST_ADDR;
		end else if (frame[4] != START_BYTE || frame[5] != ZERO_BYTE) begin
			status = ST_START;
		end else if (frame[6] != LEN_BYTE || frame[7] != ZERO_BYTE ||
				frame[8] != ZERO_BYTE || frame[9] != ZERO_BYTE) begin
			status = ST_LENGTH;
		end else if (frame[40] != TAIL_BYTE || frame[41] != TAIL_BYTE) begin
			status = ST_TAIL;
		end else begin
			status = ST_OK;
		end
	end

	// unpack little-endian fields, zero unless the frame is good
	always_comb begin
		result              = '0;
		result.status       = status;
		result.frame_length = 7'(count);
		if (status == ST_OK) begin
			result.drop_flags           = frame[14][3:0];
			result.ir_flags             = frame[15][4:0];
			result.bump_flags           = frame[17][1:0];
			result.angle_position       = {frame[19], frame[18]};
			result.left_wheel_position  = {frame[23], frame[22], frame[21], frame[20]};
			result.right_wheel_position = {frame[27], frame[26], frame[25], frame[24]};
			result.linear_velocity      = {frame[31], frame[30], frame[29], frame[28]};
			result.turn_velocity        = {frame[35], frame[34], frame[33], frame[32]};
			result.battery_level        = frame[37];
		end
	end

endmodule

[rtl/escaped_sensor_frame_decoder.sv]
// top level of the escaped sensor frame decoder
//
// Takes one raw frame byte per cycle and, on the byte flagged as frame end, delivers one
// result transaction with a check status, the unescaped length (saturated at STORE_DEPTH)
// and the unpacked sensor, odometry, velocity and battery fields. A frame's last byte passes
// the input register, then the result register, before its result appears. The first
// PLAIN_PREFIX bytes of a frame are stored verbatim, later ones have escapes removed. Only the
// first 42 unescaped bytes are kept, in registers; further bytes are counted only. The input
// stalls only when a finished result is still held in the output register and the next frame
// end arrives; ordinary bytes keep flowing meanwhile.
module escaped_sensor_frame_decoder import esfd_pkg::*; #(
	parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
	parameter int PLAIN_PREFIX = PLAIN_PREFIX_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CntW = $clog2(STORE_DEPTH + 1);
	localparam int RawW = (PLAIN_PREFIX < 1) ? 1 : $clog2(PLAIN_PREFIX + 1);

	logic              valid_s1;
	item_t             item_s1;
	logic [CntW-1:0]   cnt_q;
	logic [RawW-1:0]   raw_q;
	logic              pend_q;
	frame_t            frame_q;
	frame_t            frame_d;
	logic [CntW-1:0]   cnt_d;
	logic [CntW:0]     cnt_p1;
	logic [CntW:0]     cnt_sum;
	logic              in_prefix;
	put_t              put;
	result_t           dec;
	logic              out_valid_q;
	result_t           out_q;
	logic              out_free;
	logic              s1_go;

	// handshake between input register and result register
	assign out_free   = !out_valid_q || !result_stall;
	assign s1_go      = valid_s1 && (!item_s1.frame_end || out_free);
	assign item_stall = valid_s1 && !s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// escape removal
	assign in_prefix = (raw_q != RawW'(PLAIN_PREFIX));

	esfd_unescape u_unescape (
		.data_byte (item_s1.data_byte),
		.frame_end (item_s1.frame_end),
		.in_prefix (in_prefix),
		.pending   (pend_q),
		.put       (put)
	);

	// store update and saturating count
	assign cnt_p1  = {1'b0, cnt_q} + 1'b1;
	assign cnt_sum = {1'b0, cnt_q} + (CntW + 1)'(put.count);
	assign cnt_d   = (cnt_sum > (CntW + 1)'(STORE_DEPTH)) ? CntW'(STORE_DEPTH)
		: cnt_sum[CntW-1:0];

	always_comb begin
		frame_d = frame_q;
		for (int i = 0; i < CAP_BYTES; i++) begin
			if (put.count != 2'd0 && cnt_q == CntW'(i)) begin
				frame_d[i] = put.first;
			end
			if (put.count == 2'd2 && cnt_p1 == (CntW + 1)'(i)) begin
				frame_d[i] = put.second;
			end
		end
	end

	// decode from the store as it stands after this byte
	esfd_check #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_check (
		.frame  (frame_d),
		.count  (cnt_d),
		.result (dec)
	);

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			raw_q  <= '0;
			pend_q <= 1'b0;
		end else if (s1_go) begin
			if (item_s1.frame_end) begin
				cnt_q  <= '0;
				raw_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_d;
				pend_q <= put.pending;
				if (in_prefix) begin
					raw_q <= raw_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			frame_q <= frame_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && item_s1.frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_go && item_s1.frame_end) begin
			out_q <= dec;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// count never passes the store capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(STORE_DEPTH))
		else $error("byte count above store capacity");

	// an escape can only be pending once the plain prefix is done
	a_pend_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (raw_q == RawW'(PLAIN_PREFIX)))
		else $error("escape pending inside plain prefix");

	// frame state returns to zero after a frame end
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && item_s1.frame_end) |=> (cnt_q == '0 && raw_q == '0 && !pend_q))
		else $error("frame state not cleared after frame end");

	// a frame end is only taken when the result register can hold it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && item_s1.frame_end) |-> out_free)
		else $error("result overwritten while stalled");

	// data fields are zero on a failed check
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_OK) |->
		(out_q.battery_level == '0 && out_q.angle_position == '0 &&
		out_q.turn_velocity == '0 && out_q.drop_flags == '0))
		else $error("data fields set on failed frame");

endmodule
